FILE: hw/rtl/mtd_pkg.sv
// Package for the multiply-then-divide unit: widths, status codes, stage control.
// No dependencies.
package mtd_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int STATUS_WIDTH   = 2;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic    valid;
        status_t status;
    } ctrl_t;

endpackage

FILE: hw/rtl/mtd_if.sv
// Valid/ready channel interfaces for operand and result items.
// Depends on mtd_pkg for the status type.
interface mtd_req_if #(parameter int DATA_WIDTH = 64);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] multiplicand;
    logic [DATA_WIDTH-1:0] factor;
    logic [DATA_WIDTH-1:0] divisor;

    modport source (output valid, multiplicand, factor, divisor, input ready);
    modport sink   (input valid, multiplicand, factor, divisor, output ready);
endinterface

interface mtd_rsp_if #(parameter int DATA_WIDTH = 64);
    import mtd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] quotient;
    status_t               status;

    modport source (output valid, quotient, status, input ready);
    modport sink   (input valid, quotient, status, output ready);
endinterface

FILE: hw/rtl/mtd_mul.sv
// Three-stage front end: partial products, product sum, divisor checks.
// Depends on mtd_pkg.
module mtd_mul
    import mtd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    input  logic [DATA_WIDTH-1:0] d,
    output ctrl_t                 ctrl_out,
    output logic [DATA_WIDTH-1:0] rem_out,
    output logic [DATA_WIDTH-1:0] word_out,
    output logic [DATA_WIDTH-1:0] d_out
);
    localparam int HALF = (DATA_WIDTH + 1) / 2;
    localparam int PW   = 2 * HALF;
    localparam int FW   = 4 * HALF;
    localparam int W2   = 2 * DATA_WIDTH;

    logic [HALF-1:0] a0, a1, b0, b1;
    logic [PW-1:0]   p00_reg, p01_reg, p10_reg, p11_reg;
    logic [DATA_WIDTH-1:0] d1_reg, d2_reg, d3_reg;
    logic            v1_reg, v2_reg;
    logic [W2-1:0]   prod_reg;
    logic [FW-1:0]   sum_next;
    ctrl_t           ctrl_reg;
    logic [DATA_WIDTH-1:0] rem_reg, word_reg;
    status_t         st_next;

    assign a0 = a[HALF-1:0];
    assign b0 = b[HALF-1:0];
    assign a1 = HALF'({1'b0, a} >> HALF);
    assign b1 = HALF'({1'b0, b} >> HALF);

    assign sum_next = FW'(p00_reg)
                    + (FW'(p01_reg) << HALF)
                    + (FW'(p10_reg) << HALF)
                    + (FW'(p11_reg) << PW);

    always_comb
    begin
        if (d2_reg == '0)
            st_next = ST_DIV_ZERO;
        else if (prod_reg[W2-1:DATA_WIDTH] >= d2_reg)
            st_next = ST_OVERFLOW;
        else
            st_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ctrl_reg <= '{valid: 1'b0, status: ST_OK};
        end
        else if (en)
        begin
            v1_reg   <= valid_in;
            v2_reg   <= v1_reg;
            ctrl_reg <= '{valid: v2_reg, status: st_next};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg  <= a0 * b0;
            p01_reg  <= a0 * b1;
            p10_reg  <= a1 * b0;
            p11_reg  <= a1 * b1;
            d1_reg   <= d;
            prod_reg <= sum_next[W2-1:0];
            d2_reg   <= d1_reg;
            rem_reg  <= prod_reg[W2-1:DATA_WIDTH];
            word_reg <= prod_reg[DATA_WIDTH-1:0];
            d3_reg   <= d2_reg;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign word_out = word_reg;
    assign d_out    = d3_reg;
endmodule

FILE: hw/rtl/mtd_div_stage.sv
// One restoring division step: shift in a dividend bit, subtract if it fits.
// Depends on mtd_pkg.
module mtd_div_stage
    import mtd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  ctrl_t                 ctrl_in,
    input  logic [DATA_WIDTH-1:0] rem_in,
    input  logic [DATA_WIDTH-1:0] word_in,
    input  logic [DATA_WIDTH-1:0] d_in,
    output ctrl_t                 ctrl_out,
    output logic [DATA_WIDTH-1:0] rem_out,
    output logic [DATA_WIDTH-1:0] word_out,
    output logic [DATA_WIDTH-1:0] d_out
);
    logic [DATA_WIDTH:0]   trial, diff;
    logic                  fits;
    ctrl_t                 ctrl_reg;
    logic [DATA_WIDTH-1:0] rem_reg, word_reg, d_reg;

    assign trial = {rem_in, word_in[DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, d_in};
    assign fits  = !diff[DATA_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '{valid: 1'b0, status: ST_OK};
        else if (en)
            ctrl_reg <= ctrl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
            word_reg <= {word_in[DATA_WIDTH-2:0], fits};
            d_reg    <= d_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign word_out = word_reg;
    assign d_out    = d_reg;
endmodule

FILE: hw/rtl/multiply_then_divide_64.sv
// Pipeline: three multiply/check stages, then one division stage per quotient bit.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset clears all valid bits; payload registers are not reset.
// Depends on mtd_pkg, mtd_if, mtd_mul and mtd_div_stage.
module multiply_then_divide_64
    import mtd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    mtd_req_if.sink    req,
    mtd_rsp_if.source  rsp
);
    localparam int N = DATA_WIDTH;

    ctrl_t                 ctrl_s [0:N];
    logic [DATA_WIDTH-1:0] rem_s  [0:N];
    logic [DATA_WIDTH-1:0] word_s [0:N];
    logic [DATA_WIDTH-1:0] d_s    [0:N];
    logic                  en;

    assign en        = !ctrl_s[N].valid || rsp.ready;
    assign req.ready = en;

    mtd_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(req.valid),
        .a(req.multiplicand), .b(req.factor), .d(req.divisor),
        .ctrl_out(ctrl_s[0]), .rem_out(rem_s[0]), .word_out(word_s[0]), .d_out(d_s[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_div
        mtd_div_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage (
            .clk(clk), .rst_n(rst_n), .en(en),
            .ctrl_in(ctrl_s[i]), .rem_in(rem_s[i]), .word_in(word_s[i]), .d_in(d_s[i]),
            .ctrl_out(ctrl_s[i+1]), .rem_out(rem_s[i+1]),
            .word_out(word_s[i+1]), .d_out(d_s[i+1])
        );
    end

    assign rsp.valid    = ctrl_s[N].valid;
    assign rsp.status   = ctrl_s[N].status;
    assign rsp.quotient = (ctrl_s[N].status == ST_OK) ? word_s[N] : '0;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> rsp.quotient == '0)
        else $error("error status with nonzero quotient");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(word_s[N])
                                       && $stable(ctrl_s[0])))
        else $error("pipeline moved during stall");

    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_s[0].valid && en && d_s[0] == '0) |-> ctrl_s[0].status == ST_DIV_ZERO)
        else $error("zero divisor not flagged");
endmodule

FILE: sim/tb_multiply_then_divide_64.sv
// Testbench for multiply_then_divide_64: drives operand items through mtd_req_if and checks
// each quotient/status item on mtd_rsp_if against an in-bench 128-bit predictor.
// Depends on mtd_pkg, mtd_if and the multiply_then_divide_64 RTL.
module tb_multiply_then_divide_64;
    import mtd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 64;

    typedef struct packed {
        logic [W-1:0] quotient;
        status_t      status;
    } quot_item_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   hold_cycles;
    quot_item_t pending_q[$];

    mtd_req_if #(.DATA_WIDTH(W)) req ();
    mtd_rsp_if #(.DATA_WIDTH(W)) rsp ();

    multiply_then_divide_64 #(.DATA_WIDTH(W)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("multiply_then_divide_64 test failed");
        $finish;
    end

    function automatic quot_item_t predict_quotient(logic [W-1:0] a, logic [W-1:0] b,
                                                    logic [W-1:0] d);
        quot_item_t r;
        logic [2*W-1:0] prod;
        logic [2*W-1:0] q;
        r.quotient = '0;
        r.status   = ST_OK;
        if (d == '0)
        begin
            r.status = ST_DIV_ZERO;
        end
        else
        begin
            prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
            q    = prod / {{W{1'b0}}, d};
            if (q[2*W-1:W] != '0)
                r.status = ST_OVERFLOW;
            else
                r.quotient = q[W-1:0];
        end
        return r;
    endfunction

    function automatic logic [W-1:0] rand_word();
        logic [W-1:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(1, 63);
            1: v = v >> $urandom_range(32, 63);
            2: v = {W{1'b1}} - $urandom_range(0, 3);
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_operands(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] d);
        req.valid        <= 1'b1;
        req.multiplicand <= a;
        req.factor       <= b;
        req.divisor      <= d;
        pending_q = {pending_q, predict_quotient(a, b, d)};
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if ($urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // receiver: stall pattern, plus long hold when requested
    initial
    begin
        quot_item_t got;
        quot_item_t exp;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                got.quotient = rsp.quotient;
                got.status   = rsp.status;
                if (pending_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item q=%h st=%0d", got.quotient, got.status);
                end
                else
                begin
                    exp = pending_q.pop_front();
                    if (got.quotient !== exp.quotient || got.status !== exp.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp q=%h st=%0d got q=%h st=%0d",
                                     exp.quotient, exp.status, got.quotient, got.status);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(0, 7) != 0) || (($time / 2000) % 3 == 0);
        end
    end

    task automatic test_directed();
        logic [W-1:0] mx;
        mx = {W{1'b1}};
        send_operands(64'd0, 64'd0, 64'd1);
        send_operands(mx, mx, mx);
        send_operands(mx, mx, 64'd0);
        send_operands(64'd0, 64'd0, 64'd0);
        send_operands(mx, 64'd1, 64'd1);
        send_operands(mx, 64'd2, 64'd1);
        send_operands(mx, 64'd2, 64'd2);
        send_operands(mx, mx, mx - 64'd1);
        send_operands(64'h1, 64'h1, mx);
        send_operands(64'h8000_0000_0000_0000, 64'd2, 64'd2);
        send_operands(64'h8000_0000_0000_0000, 64'd2, 64'd1);
        send_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h1234_5678);
        send_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, mx);
        send_operands(64'd7, 64'd3, 64'd2);
        send_operands(mx, 64'd0, 64'd0);
        req.valid <= 1'b0;
    endtask

    task automatic test_random();
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] d;
        repeat (335)
        begin
            a = rand_word();
            b = rand_word();
            case ($urandom_range(0, 9))
                0: d = '0;
                1: d = a;
                2: d = rand_word() >> $urandom_range(40, 63);
                default: d = rand_word();
            endcase
            send_operands(a, b, d);
            if ($urandom_range(0, 15) == 0)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(5, 20)) @(posedge clk);
            end
        end
        req.valid <= 1'b0;
    endtask

    task automatic test_backpressure();
        hold_cycles = 200;
        repeat (150)
            send_operands(rand_word(), rand_word(), rand_word());
        req.valid <= 1'b0;
    endtask

    initial
    begin
        int guard;
        rst_n            = 1'b0;
        mismatches       = 0;
        hold_cycles      = 0;
        req.valid        = 1'b0;
        req.multiplicand = '0;
        req.factor       = '0;
        req.divisor      = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        guard = 0;
        while (pending_q.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (W + 10) @(posedge clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("multiply_then_divide_64 test passed");
        else
            $display("multiply_then_divide_64 test failed");
        $finish;
    end
endmodule
